// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sbcd_pkg.sv
// ----------------------------------------------------------------------------
// sbcd_pkg
// constants, types and reply tables of the block command decoder
// ----------------------------------------------------------------------------
package sbcd_pkg;

	// disk geometry
	localparam int unsigned DISK_BLOCKS = 131072;
	localparam int unsigned BLOCK_BYTES = 512;

	localparam int BB_W   = $clog2(BLOCK_BYTES) + 1;
	localparam int TOT_W  = 16 + BB_W;
	localparam int XFER_W = 25;
	localparam int LEN_W  = (TOT_W > XFER_W) ? TOT_W : XFER_W;
	localparam int OFF_W  = 32 + BB_W;
	localparam int DOFF_W = 41;
	localparam int CNT_W  = 6;

	localparam logic [XFER_W-1:0] XFER_MAX = '1;
	localparam logic [OFF_W-1:0] DISK_BYTES =
		OFF_W'(64'(DISK_BLOCKS) * 64'(BLOCK_BYTES));
	localparam logic [31:0] CAP_LBA = 32'(64'(DISK_BLOCKS) - 64'd1);
	localparam logic [31:0] CAP_BSZ = 32'(BLOCK_BYTES);

	// operation codes
	localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
	localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
	localparam logic [7:0] OP_INQUIRY         = 8'h12;
	localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
	localparam logic [7:0] OP_START_STOP      = 8'h1B;
	localparam logic [7:0] OP_PREVENT_ALLOW   = 8'h1E;
	localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
	localparam logic [7:0] OP_READ10          = 8'h28;
	localparam logic [7:0] OP_WRITE10         = 8'h2A;
	localparam logic [7:0] OP_MODE_SENSE10    = 8'h5A;

	localparam logic [4:0] RW_MIN_CDB  = 5'd10;
	localparam logic [4:0] VPD_MIN_CDB = 5'd2;

	// built-in reply lengths
	localparam int SENSE_LEN = 18;
	localparam int INQ_LEN   = 36;
	localparam int MS6_LEN   = 4;
	localparam int MS10_LEN  = 8;
	localparam int CAP_LEN   = 8;

	localparam logic [7:0] SENSE_RESP_CODE = 8'h70;
	localparam logic [7:0] SENSE_ADD_LEN   = 8'd10;
	localparam logic [7:0] MS6_DATA_LEN    = 8'h03;

	localparam logic [CNT_W-1:0] SENSE_ADD_IDX = CNT_W'(7);

	// standard inquiry data: peripheral info, vendor, product, revision
	localparam logic [7:0] INQ_TABLE [INQ_LEN] = '{
		8'h00, 8'h80, 8'h06, 8'h02, 8'd31, 8'h00, 8'h00, 8'h00,
		8'h47, 8'h45, 8'h4E, 8'h45, 8'h52, 8'h49, 8'h43, 8'h20,
		8'h52, 8'h41, 8'h4D, 8'h20, 8'h44, 8'h49, 8'h53, 8'h4B,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
		8'h30, 8'h30, 8'h30, 8'h31
	};

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_TO_HOST,
		DIR_FROM_HOST
	} dir_t;

	typedef enum logic [2:0] {
		RK_NONE,
		RK_SENSE,
		RK_INQ,
		RK_ZERO,
		RK_MS6,
		RK_CAP
	} reply_kind_t;

	// command word as taken from the input channel
	typedef struct packed {
		logic [7:0]  opcode;
		logic        vpd_flag;
		logic [4:0]  cdb_length;
		logic [31:0] start_block;
		logic [15:0] num_blocks;
		logic [31:0] host_length;
		logic [31:0] host_buffer_size;
	} cmd_in_t;

	// decoded command, before the disk end clamp
	typedef struct packed {
		dir_t              dir;
		logic              status;
		reply_kind_t       kind;
		logic              is_rw;
		logic [LEN_W-1:0]  len0;
		logic [OFF_W-1:0]  off;
		logic [OFF_W-1:0]  rem;
		logic              off_past;
		logic [31:0]       bufsz;
	} dec_t;

	// descriptor held by the reply emitter
	typedef struct packed {
		dir_t              dir;
		logic              status;
		logic [XFER_W-1:0] xfer;
		logic [DOFF_W-1:0] doff;
		logic              en;
		reply_kind_t       kind;
		logic              byte_ok;
		logic [CNT_W-1:0]  last_idx;
	} desc_t;

	// one result word
	typedef struct packed {
		dir_t              dir;
		logic              status;
		logic [XFER_W-1:0] xfer;
		logic [DOFF_W-1:0] doff;
		logic              en;
		logic [7:0]        data;
		logic              byte_valid;
		logic              last;
	} res_t;

	function automatic logic [7:0] reply_byte(reply_kind_t kind, logic [CNT_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (kind)
			RK_SENSE: begin
				if (idx == '0)
					b = SENSE_RESP_CODE;
				else if (idx == SENSE_ADD_IDX)
					b = SENSE_ADD_LEN;
			end
			RK_INQ: begin
				if (idx < CNT_W'(INQ_LEN))
					b = INQ_TABLE[idx];
			end
			RK_MS6: begin
				if (idx == '0)
					b = MS6_DATA_LEN;
			end
			RK_CAP: begin
				case (idx)
					CNT_W'(0): b = CAP_LBA[31:24];
					CNT_W'(1): b = CAP_LBA[23:16];
					CNT_W'(2): b = CAP_LBA[15:8];
					CNT_W'(3): b = CAP_LBA[7:0];
					CNT_W'(4): b = CAP_BSZ[31:24];
					CNT_W'(5): b = CAP_BSZ[23:16];
					CNT_W'(6): b = CAP_BSZ[15:8];
					CNT_W'(7): b = CAP_BSZ[7:0];
					default:   b = 8'h00;
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/core/sbcd_decode.sv
// ----------------------------------------------------------------------------
// sbcd_decode
// opcode decode, reply length, byte offset and remaining disk bytes
// ----------------------------------------------------------------------------
module sbcd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  sbcd_pkg::cmd_in_t cmd_s1,
	input  logic              s3_ready,
	output logic              s2_ready,
	output logic              s2_valid,
	output sbcd_pkg::dec_t    dec_s2
);
	import sbcd_pkg::*;

	dec_t              dec;
	logic              s2_v_q;
	logic [TOT_W-1:0]  total;

	function automatic logic [LEN_W-1:0] clamp_len(logic [31:0] hlen, int n);
		return (hlen < 32'(n)) ? LEN_W'(hlen) : LEN_W'(n);
	endfunction

	always_comb begin
		total        = TOT_W'(cmd_s1.num_blocks) * TOT_W'(BLOCK_BYTES);
		dec          = '0;
		dec.dir      = DIR_NONE;
		dec.kind     = RK_NONE;
		dec.bufsz    = cmd_s1.host_buffer_size;
		dec.off      = OFF_W'(cmd_s1.start_block) * OFF_W'(BLOCK_BYTES);
		dec.off_past = (dec.off >= DISK_BYTES);
		dec.rem      = DISK_BYTES - dec.off;
		if (cmd_s1.cdb_length == '0) begin
			dec.status = 1'b1;
		end else begin
			case (cmd_s1.opcode)
				OP_TEST_UNIT_READY, OP_START_STOP, OP_PREVENT_ALLOW: begin
					dec.status = 1'b0;
				end
				OP_REQUEST_SENSE: begin
					dec.dir  = DIR_TO_HOST;
					dec.len0 = clamp_len(cmd_s1.host_length, SENSE_LEN);
					dec.kind = RK_SENSE;
				end
				OP_INQUIRY: begin
					dec.dir  = DIR_TO_HOST;
					dec.len0 = clamp_len(cmd_s1.host_length, INQ_LEN);
					// vpd bit only exists once byte 1 was sent
					dec.kind = (cmd_s1.cdb_length >= VPD_MIN_CDB && cmd_s1.vpd_flag)
						? RK_ZERO : RK_INQ;
				end
				OP_MODE_SENSE6: begin
					dec.dir  = DIR_TO_HOST;
					dec.len0 = clamp_len(cmd_s1.host_length, MS6_LEN);
					dec.kind = RK_MS6;
				end
				OP_MODE_SENSE10: begin
					dec.dir  = DIR_TO_HOST;
					dec.len0 = clamp_len(cmd_s1.host_length, MS10_LEN);
					dec.kind = RK_ZERO;
				end
				OP_READ_CAPACITY: begin
					dec.dir  = DIR_TO_HOST;
					dec.len0 = clamp_len(cmd_s1.host_length, CAP_LEN);
					dec.kind = RK_CAP;
				end
				OP_READ10, OP_WRITE10: begin
					if (cmd_s1.cdb_length < RW_MIN_CDB) begin
						dec.status = 1'b1;
					end else begin
						dec.dir   = (cmd_s1.opcode == OP_READ10) ? DIR_TO_HOST : DIR_FROM_HOST;
						dec.is_rw = 1'b1;
						dec.len0  = (cmd_s1.host_length < 32'(total))
							? LEN_W'(cmd_s1.host_length) : LEN_W'(total);
					end
				end
				default: begin
					dec.status = 1'b1;
				end
			endcase
		end
	end

	assign s2_ready = !s2_v_q || s3_ready;
	assign s2_valid = s2_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_ready) begin
			s2_v_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_valid) begin
			dec_s2 <= dec;
		end
	end

endmodule

// File: rtl/core/sbcd_emit.sv
// ----------------------------------------------------------------------------
// sbcd_emit
// disk end clamp, reply descriptor and one result word per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbcd_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s2_valid,
	input  sbcd_pkg::dec_t                     dec_s2,
	output logic                               s3_ready,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         direction,
	output logic                               status,
	output logic [sbcd_pkg::XFER_W-1:0]        transfer_length,
	output logic [sbcd_pkg::DOFF_W-1:0]        disk_offset,
	output logic                               transfer_enable,
	output logic [7:0]                         data_byte,
	output logic                               byte_valid,
	output logic                               last
);
	import sbcd_pkg::*;

	desc_t             desc;
	desc_t             desc_s3;
	logic              s3_v_q;
	logic [CNT_W-1:0]  idx_q;
	logic              out_v_q;
	res_t              res_q;
	logic [LEN_W-1:0]  len;
	logic              cut;
	logic              out_free;
	logic              emit_fire;
	logic              is_last;

	// clamp at the disk end and build the reply descriptor
	always_comb begin
		cut = dec_s2.is_rw && (dec_s2.len0 != '0)
			&& (dec_s2.off_past || (OFF_W'(dec_s2.len0) > dec_s2.rem));
		len = dec_s2.len0;
		if (cut)
			len = dec_s2.off_past ? '0 : LEN_W'(dec_s2.rem);

		desc          = '0;
		desc.dir      = dec_s2.dir;
		desc.status   = dec_s2.status;
		desc.kind     = dec_s2.kind;
		desc.xfer     = (LEN_W'(XFER_MAX) < len) ? XFER_MAX : XFER_W'(len);
		desc.doff     = dec_s2.is_rw ? dec_s2.off[DOFF_W-1:0] : '0;
		desc.en       = dec_s2.is_rw && (len != '0) && (32'(len) <= dec_s2.bufsz);
		desc.byte_ok  = (dec_s2.kind != RK_NONE) && (len != '0);
		desc.last_idx = desc.byte_ok ? CNT_W'(len - LEN_W'(1)) : '0;
	end

	assign out_free  = !out_v_q || !out_stall;
	assign emit_fire = s3_v_q && out_free;
	assign is_last   = (idx_q == desc_s3.last_idx);
	assign s3_ready  = !s3_v_q || (emit_fire && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q  <= 1'b0;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (s3_ready)
				s3_v_q <= s2_valid;
			if (emit_fire)
				idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
			if (emit_fire)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && s2_valid)
			desc_s3 <= desc;
		if (emit_fire) begin
			res_q.dir        <= desc_s3.dir;
			res_q.status     <= desc_s3.status;
			res_q.xfer       <= desc_s3.xfer;
			res_q.doff       <= desc_s3.doff;
			res_q.en         <= desc_s3.en;
			res_q.data       <= desc_s3.byte_ok ? reply_byte(desc_s3.kind, idx_q) : 8'h00;
			res_q.byte_valid <= desc_s3.byte_ok;
			res_q.last       <= is_last;
		end
	end

	assign out_valid       = out_v_q;
	assign direction       = res_q.dir;
	assign status          = res_q.status;
	assign transfer_length = res_q.xfer;
	assign disk_offset     = res_q.doff;
	assign transfer_enable = res_q.en;
	assign data_byte       = res_q.data;
	assign byte_valid      = res_q.byte_valid;
	assign last            = res_q.last;

	`ASSERT_IMPL(a_idx_in_range, s3_v_q, idx_q <= desc_s3.last_idx, "reply index past end")
	`ASSERT_NEXT(a_idx_rewinds, emit_fire && is_last, idx_q == '0, "index not cleared after last")
	`ASSERT_IMPL(a_nobyte_single, out_v_q && !res_q.byte_valid, res_q.last,
		"word without data byte is not the only word")
	`ASSERT_IMPL(a_enable_rw, out_v_q && res_q.en,
		!res_q.status && !res_q.byte_valid && res_q.dir != DIR_NONE,
		"transfer enable outside read or write")

endmodule

// File: rtl/core/scsi_block_command_decoder.sv
// ----------------------------------------------------------------------------
// scsi_block_command_decoder
// decodes one mass-storage command word into status, direction, lengths and
// built-in reply bytes
// ----------------------------------------------------------------------------
// A command word is taken in every cycle in which the input register can move
// on. Each command gives max(1, reply length) result words, one per cycle
// while the output is not stalled, so a command gives 1 to 36 result words: the
// reply emitter with its byte index is the part that sets this. The first
// result word of a command passes the input register, decode register,
// descriptor register, then the result register. READ(10) and WRITE(10) and
// the commands without data give a single word.
module scsi_block_command_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      opcode,
	input  logic                            vpd_flag,
	input  logic [4:0]                      cdb_length,
	input  logic [31:0]                     start_block,
	input  logic [15:0]                     num_blocks,
	input  logic [31:0]                     host_length,
	input  logic [31:0]                     host_buffer_size,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      direction,
	output logic                            status,
	output logic [sbcd_pkg::XFER_W-1:0]     transfer_length,
	output logic [sbcd_pkg::DOFF_W-1:0]     disk_offset,
	output logic                            transfer_enable,
	output logic [7:0]                      data_byte,
	output logic                            byte_valid,
	output logic                            last
);
	import sbcd_pkg::*;

	cmd_in_t  cmd_s1;
	logic     s1_v_q;
	logic     s1_ready;
	logic     s2_ready;
	logic     s2_valid;
	dec_t     dec_s2;
	logic     s3_ready;

	assign s1_ready = !s1_v_q || s2_ready;
	assign in_stall = !s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_ready) begin
			s1_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			cmd_s1.opcode           <= opcode;
			cmd_s1.vpd_flag         <= vpd_flag;
			cmd_s1.cdb_length       <= cdb_length;
			cmd_s1.start_block      <= start_block;
			cmd_s1.num_blocks       <= num_blocks;
			cmd_s1.host_length      <= host_length;
			cmd_s1.host_buffer_size <= host_buffer_size;
		end
	end

	sbcd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_v_q),
		.cmd_s1   (cmd_s1),
		.s3_ready (s3_ready),
		.s2_ready (s2_ready),
		.s2_valid (s2_valid),
		.dec_s2   (dec_s2)
	);

	sbcd_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.s2_valid        (s2_valid),
		.dec_s2          (dec_s2),
		.s3_ready        (s3_ready),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.direction       (direction),
		.status          (status),
		.transfer_length (transfer_length),
		.disk_offset     (disk_offset),
		.transfer_enable (transfer_enable),
		.data_byte       (data_byte),
		.byte_valid      (byte_valid),
		.last            (last)
	);

endmodule
